FILE: design/oapt_pkg.sv
// Package for the oscillation amplitude and period tracker.
// Holds the item types, register indexes, widths and reset values used by every module.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package oapt_pkg;

    // Number of axes that carry a tracking lane, and the number of axes in an item.
    localparam int AXES         = 3;
    localparam int NUM_OUT_AXES = 3;

    // Width of the tick counter and of every timestamp.
    localparam int TICK_BITS = 32;

    // Width used when a tick difference is compared against the timeout register.
    localparam int TIMEOUT_W = 32;
    localparam int CMP_W     = (TICK_BITS > TIMEOUT_W) ? TICK_BITS : TIMEOUT_W;

    // Register file layout.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEAD_BAND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SKIP      = 2'd2;

    localparam int DEAD_BAND_W = 15;
    localparam int SKIP_W      = 4;

    // Reset values of the registers.
    localparam logic [DEAD_BAND_W-1:0] DEAD_BAND_RESET = 15'd64;
    localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET   = 32'd5000;
    localparam logic [SKIP_W-1:0]      SKIP_RESET      = 4'd3;

    typedef logic [TICK_BITS-1:0] tick_t;

    // Configuration seen by the lanes.
    typedef struct packed {
        logic [DEAD_BAND_W-1:0] dead_band;
        logic [TIMEOUT_W-1:0]   timeout_ticks;
    } cfg_t;

    // One input item: a sample tick of three angles.
    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
    } in_item_t;

    // What one lane reports for its axis.
    typedef struct packed {
        logic signed [15:0] offset;
        logic [14:0]        amplitude;
        logic [31:0]        period;
        logic               valid;
    } lane_res_t;

    // One result item.
    typedef struct packed {
        logic signed [15:0] offset_x;
        logic [14:0]        amplitude_x;
        logic [31:0]        period_x;
        logic               valid_x;
        logic signed [15:0] offset_y;
        logic [14:0]        amplitude_y;
        logic [31:0]        period_y;
        logic               valid_y;
        logic signed [15:0] offset_z;
        logic [14:0]        amplitude_z;
        logic [31:0]        period_z;
        logic               valid_z;
    } out_item_t;

    // Selects the angle of one axis from an input item.
    function automatic logic signed [15:0] pick_angle(input in_item_t item, input int axis);
        logic signed [15:0] ang;
        case (axis)
            0:       ang = item.angle_x;
            1:       ang = item.angle_y;
            2:       ang = item.angle_z;
            default: ang = '0;
        endcase
        return ang;
    endfunction

endpackage

`default_nettype wire

FILE: design/oapt_cfg.sv
// Configuration register file of the oscillation tracker.
// Decodes writes on the configuration channel; uses oapt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oapt_cfg
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [oapt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [oapt_pkg::CFG_DATA_W-1:0] cfg_data,
    output oapt_pkg::cfg_t                       cfg
);

    logic [oapt_pkg::DEAD_BAND_W-1:0] dead_band_reg;
    logic [oapt_pkg::TIMEOUT_W-1:0]   timeout_reg;
    logic                             wr_en;

    // Writes are always taken at once.
    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;

    // Register writes. The skip count only matters through its reset value, which the
    // lanes load into their skip counters, so a write to it is taken and has no effect.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_band_reg <= oapt_pkg::DEAD_BAND_RESET;
            timeout_reg   <= oapt_pkg::TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            case (cfg_index)
                oapt_pkg::CFG_IDX_DEAD_BAND:
                begin
                    dead_band_reg <= cfg_data[oapt_pkg::DEAD_BAND_W-1:0];
                end
                oapt_pkg::CFG_IDX_TIMEOUT:
                begin
                    timeout_reg <= cfg_data[oapt_pkg::TIMEOUT_W-1:0];
                end
                oapt_pkg::CFG_IDX_SKIP:
                begin
                    dead_band_reg <= dead_band_reg;
                end
                default:
                begin
                    timeout_reg <= timeout_reg;
                end
            endcase
        end
    end

    assign cfg.dead_band     = dead_band_reg;
    assign cfg.timeout_ticks = timeout_reg;

endmodule

`default_nettype wire

FILE: design/oapt_lane.sv
// One axis lane of the oscillation tracker: peak and trough tracking, latching, period.
// Updates its state on every accepted item; uses oapt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oapt_lane
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic signed [15:0] angle,
    input  wire oapt_pkg::tick_t    tick,
    input  wire oapt_pkg::cfg_t     cfg,
    output oapt_pkg::lane_res_t     res
);

    // Running and held extremes. A peak never goes below zero and a trough never above.
    logic [14:0]        peak_reg,        peak_next;
    logic signed [15:0] trough_reg,      trough_next;
    logic [14:0]        held_peak_reg,   held_peak_next;
    logic signed [15:0] held_trough_reg, held_trough_next;

    // Timestamps of the running extremes and of the last two latches.
    oapt_pkg::tick_t peak_time_reg,    peak_time_next;
    oapt_pkg::tick_t trough_time_reg,  trough_time_next;
    oapt_pkg::tick_t peak_begin_reg,   peak_begin_next;
    oapt_pkg::tick_t peak_end_reg,     peak_end_next;
    oapt_pkg::tick_t trough_begin_reg, trough_begin_next;
    oapt_pkg::tick_t trough_end_reg,   trough_end_next;
    oapt_pkg::tick_t period_reg,       period_next;

    logic [oapt_pkg::SKIP_W-1:0] peak_skip_reg,   peak_skip_next;
    logic [oapt_pkg::SKIP_W-1:0] trough_skip_reg, trough_skip_next;
    logic                        arm_peak_reg,    arm_peak_next;
    logic                        arm_trough_reg,  arm_trough_next;

    logic signed [16:0] angle_e;
    logic signed [16:0] db_e;
    logic               in_neg;
    logic               in_pos;

    logic                       ready;
    logic                       timed_out;
    oapt_pkg::tick_t            age_p;
    oapt_pkg::tick_t            age_t;
    logic signed [16:0]         sum;
    logic signed [16:0]         dif;

    // Which half the sample lies in, strictly beyond the dead band.
    assign angle_e = {angle[15], angle};
    assign db_e    = $signed({2'b00, cfg.dead_band});
    assign in_neg  = angle_e < -db_e;
    assign in_pos  = angle_e > db_e;

    // Next state of the lane for this item.
    always_comb
    begin
        peak_next         = peak_reg;
        trough_next       = trough_reg;
        held_peak_next    = held_peak_reg;
        held_trough_next  = held_trough_reg;
        peak_time_next    = peak_time_reg;
        trough_time_next  = trough_time_reg;
        peak_begin_next   = peak_begin_reg;
        peak_end_next     = peak_end_reg;
        trough_begin_next = trough_begin_reg;
        trough_end_next   = trough_end_reg;
        period_next       = period_reg;
        peak_skip_next    = peak_skip_reg;
        trough_skip_next  = trough_skip_reg;
        arm_peak_next     = arm_peak_reg;
        arm_trough_next   = arm_trough_reg;

        // Negative half: follow the trough, and latch the peak of the half that ended.
        if (in_neg)
        begin
            if (angle < trough_reg)
            begin
                trough_next      = angle;
                trough_time_next = tick;
            end
            if (arm_peak_reg)
            begin
                held_peak_next  = peak_reg;
                peak_begin_next = peak_end_reg;
                peak_end_next   = peak_time_reg;
                if (peak_skip_reg != '0)
                begin
                    peak_skip_next = peak_skip_reg - 1'b1;
                end
                if (peak_skip_next == '0)
                begin
                    period_next = peak_time_reg - peak_end_reg;
                end
            end
            peak_next       = '0;
            arm_peak_next   = 1'b0;
            arm_trough_next = 1'b1;
        end

        // Positive half: follow the peak, and latch the trough of the half that ended.
        if (in_pos)
        begin
            if (angle[14:0] > peak_reg)
            begin
                peak_next      = angle[14:0];
                peak_time_next = tick;
            end
            if (arm_trough_reg)
            begin
                held_trough_next  = trough_reg;
                trough_begin_next = trough_end_reg;
                trough_end_next   = trough_time_reg;
                if (trough_skip_reg != '0)
                begin
                    trough_skip_next = trough_skip_reg - 1'b1;
                end
                if (trough_skip_next == '0)
                begin
                    period_next = trough_time_reg - trough_end_reg;
                end
            end
            trough_next     = '0;
            arm_trough_next = 1'b0;
            arm_peak_next   = 1'b1;
        end
    end

    // Lane state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg         <= '0;
            trough_reg       <= '0;
            held_peak_reg    <= '0;
            held_trough_reg  <= '0;
            peak_time_reg    <= '0;
            trough_time_reg  <= '0;
            peak_begin_reg   <= '0;
            peak_end_reg     <= '0;
            trough_begin_reg <= '0;
            trough_end_reg   <= '0;
            period_reg       <= '0;
            peak_skip_reg    <= oapt_pkg::SKIP_RESET;
            trough_skip_reg  <= oapt_pkg::SKIP_RESET;
            arm_peak_reg     <= 1'b1;
            arm_trough_reg   <= 1'b1;
        end
        else if (accept)
        begin
            peak_reg         <= peak_next;
            trough_reg       <= trough_next;
            held_peak_reg    <= held_peak_next;
            held_trough_reg  <= held_trough_next;
            peak_time_reg    <= peak_time_next;
            trough_time_reg  <= trough_time_next;
            peak_begin_reg   <= peak_begin_next;
            peak_end_reg     <= peak_end_next;
            trough_begin_reg <= trough_begin_next;
            trough_end_reg   <= trough_end_next;
            period_reg       <= period_next;
            peak_skip_reg    <= peak_skip_next;
            trough_skip_reg  <= trough_skip_next;
            arm_peak_reg     <= arm_peak_next;
            arm_trough_reg   <= arm_trough_next;
        end
    end

    // The result is meaningful once either skip counter has run out and at least one
    // latch is recent enough.
    assign ready     = (peak_skip_next == '0) || (trough_skip_next == '0);
    assign age_p     = tick - peak_begin_next;
    assign age_t     = tick - trough_begin_next;
    assign timed_out = (oapt_pkg::CMP_W'(age_p) > oapt_pkg::CMP_W'(cfg.timeout_ticks))
                    && (oapt_pkg::CMP_W'(age_t) > oapt_pkg::CMP_W'(cfg.timeout_ticks));

    // Offset and amplitude of the held extremes, halved by a shift.
    assign sum = $signed({2'b00, held_peak_next}) + $signed({held_trough_next[15],
                                                              held_trough_next});
    assign dif = $signed({2'b00, held_peak_next}) - $signed({held_trough_next[15],
                                                              held_trough_next});

    always_comb
    begin
        if (ready && !timed_out)
        begin
            res.offset    = sum[16:1];
            res.amplitude = dif[15:1];
            res.period    = 32'(period_next);
            res.valid     = 1'b1;
        end
        else
        begin
            res = '0;
        end
    end

endmodule

`default_nettype wire

FILE: design/oapt_merge.sv
// Merging stage of the oscillation tracker: tick counter, handshake and output register.
// Gathers the lane results into one item; uses oapt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oapt_merge
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output oapt_pkg::out_item_t      out_data,
    output logic                     accept,
    output oapt_pkg::tick_t          tick,
    input  wire oapt_pkg::lane_res_t res [oapt_pkg::NUM_OUT_AXES]
);

    logic                out_valid_reg;
    oapt_pkg::out_item_t out_data_reg;
    oapt_pkg::out_item_t out_data_next;
    oapt_pkg::tick_t     tick_reg;

    // An item is taken whenever the output register is empty or drains this cycle.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Pack the lane results in axis order.
    always_comb
    begin
        out_data_next.offset_x    = res[0].offset;
        out_data_next.amplitude_x = res[0].amplitude;
        out_data_next.period_x    = res[0].period;
        out_data_next.valid_x     = res[0].valid;
        out_data_next.offset_y    = res[1].offset;
        out_data_next.amplitude_y = res[1].amplitude;
        out_data_next.period_y    = res[1].period;
        out_data_next.valid_y     = res[1].valid;
        out_data_next.offset_z    = res[2].offset;
        out_data_next.amplitude_z = res[2].amplitude;
        out_data_next.period_z    = res[2].period;
        out_data_next.valid_z     = res[2].valid;
    end

    // Tick counter and output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                tick_reg      <= tick_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign tick      = tick_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: design/oscillation_amplitude_period_tracker.sv
// Oscillation amplitude and period tracker, a set of parallel axis lanes and a merging stage.
// Top level; instantiates oapt_cfg, oapt_lane and oapt_merge and uses oapt_pkg.
//
// The block takes one item of three angles in every clock cycle while in_stall is low and
// gives one result item for each, in the cycle after it is taken. Each axis has its own lane
// whose compare-and-latch logic, together with a 32-bit timestamp subtract and timeout compare,
// settles in the cycle the item is taken; the merging stage's output register holds the result,
// so input stall is raised only while that register is full and the output side is stalling.
// Configuration writes are taken at once. A write to the skip count is accepted but has no
// effect: the skip counters always start from the reset value of the skip count.
`timescale 1ns / 1ps
`default_nettype none

module oscillation_amplitude_period_tracker
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire oapt_pkg::in_item_t              in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output oapt_pkg::out_item_t                  out_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [oapt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [oapt_pkg::CFG_DATA_W-1:0] cfg_data
);

    oapt_pkg::cfg_t      cfg;
    oapt_pkg::tick_t     tick;
    logic                accept;
    oapt_pkg::lane_res_t res [oapt_pkg::NUM_OUT_AXES];

    // Configuration registers.
    oapt_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // One lane for each tracked axis; the axes without a lane report zero.
    for (genvar n = 0; n < oapt_pkg::NUM_OUT_AXES; n++)
    begin : g_lane
        if (n < oapt_pkg::AXES)
        begin : g_used
            oapt_lane u_lane
            (
                .clk    (clk),
                .rst_n  (rst_n),
                .accept (accept),
                .angle  (oapt_pkg::pick_angle(in_data, n)),
                .tick   (tick),
                .cfg    (cfg),
                .res    (res[n])
            );
        end
        else
        begin : g_unused
            assign res[n] = '0;
        end
    end

    // Handshake, tick counter and output register.
    oapt_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .accept    (accept),
        .tick      (tick),
        .res       (res)
    );

endmodule

`default_nettype wire

FILE: design/oapt_checker.sv
// Port checker for the oscillation tracker, bound to the top level.
// Watches the handshakes and result items; uses oapt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oapt_checker
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire oapt_pkg::out_item_t out_data,
    input wire logic                cfg_valid,
    input wire logic                cfg_ready
);

    // A result that is stalled stays in place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result item changed");

    // The input side is only held off by a full, stalled output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // Every taken item gives a result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("taken item gave no result");

    // An x axis result that is not valid reports zeros.
    a_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.valid_x |->
            out_data.offset_x == '0 && out_data.amplitude_x == '0 && out_data.period_x == '0)
        else $error("invalid x result is not zero");

    // Configuration writes are never held off.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write held off");

endmodule

bind oscillation_amplitude_period_tracker oapt_checker u_oapt_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the oscillation amplitude and period tracker.
// It predicts each result item from the accepted sample items and checks the outputs field by field.
// Depends on oapt_pkg and the oscillation_amplitude_period_tracker top level.
`timescale 1ns / 1ps

module tb_top;

    localparam int HOLD_OFF_CYCLES = 150;
    localparam int NUM_DIRECTED    = 23;

    // A register index that the block does not decode.
    localparam logic [oapt_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    // Per-axis view of one result item, laid out exactly as out_item_t.
    typedef oapt_pkg::lane_res_t [0:oapt_pkg::NUM_OUT_AXES-1] lane_set_t;

    // Tracking state that the bench keeps for one axis.
    typedef struct {
        int        run_peak;
        int        run_trough;
        bit [31:0] peak_time;
        bit [31:0] trough_time;
        int        held_peak;
        int        held_trough;
        bit [31:0] peak_begin;
        bit [31:0] peak_end;
        bit [31:0] trough_begin;
        bit [31:0] trough_end;
        bit [3:0]  peak_skip;
        bit [3:0]  trough_skip;
        bit [31:0] period;
        bit        arm_peak;
        bit        arm_trough;
    } swing_state_t;

    // Predicts the swing of every axis and holds the result items still to arrive.
    class oscillation_scoreboard;
        swing_state_t axis_state[oapt_pkg::NUM_OUT_AXES];
        bit [oapt_pkg::DEAD_BAND_W-1:0] dead_band;
        bit [oapt_pkg::TIMEOUT_W-1:0]   timeout_ticks;
        bit [oapt_pkg::SKIP_W-1:0]      skip_count;
        bit [oapt_pkg::TICK_BITS-1:0]   tick;
        lane_set_t                      expected_results[$];
        int                             failures;

        function new();
            dead_band     = oapt_pkg::DEAD_BAND_RESET;
            timeout_ticks = oapt_pkg::TIMEOUT_RESET;
            skip_count    = oapt_pkg::SKIP_RESET;
            tick          = '0;
            failures      = 0;
            foreach (axis_state[n])
            begin
                axis_state[n]             = '{default: 0};
                axis_state[n].peak_skip   = skip_count;
                axis_state[n].trough_skip = skip_count;
                axis_state[n].arm_peak    = 1'b1;
                axis_state[n].arm_trough  = 1'b1;
            end
        endfunction

        // The skip count is only kept here; it reaches the counters at reset alone.
        function void note_cfg(logic [oapt_pkg::CFG_IDX_W-1:0] idx,
                               logic [oapt_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                oapt_pkg::CFG_IDX_DEAD_BAND: dead_band     = data[oapt_pkg::DEAD_BAND_W-1:0];
                oapt_pkg::CFG_IDX_TIMEOUT:   timeout_ticks = data[oapt_pkg::TIMEOUT_W-1:0];
                oapt_pkg::CFG_IDX_SKIP:      skip_count    = data[oapt_pkg::SKIP_W-1:0];
                default:                     ;
            endcase
        endfunction

        // Advances every axis by one accepted sample item and queues the expected result.
        function void note_sample(oapt_pkg::in_item_t item);
            swing_state_t s;
            lane_set_t    want;
            int           angles[oapt_pkg::NUM_OUT_AXES];
            int           db;
            int           sum;
            int           dif;
            bit [31:0]    age_t;
            bit [31:0]    age_p;

            angles[0] = item.angle_x;
            angles[1] = item.angle_y;
            angles[2] = item.angle_z;
            db = int'(dead_band);
            for (int n = 0; n < oapt_pkg::NUM_OUT_AXES; n++)
            begin
                // An axis without a lane always reports zeros.
                want[n] = '0;
                if (n >= oapt_pkg::AXES)
                    continue;
                s = axis_state[n];
                // Negative half: follow the trough and latch the finished peak once.
                if (angles[n] < -db)
                begin
                    if (angles[n] < s.run_trough)
                    begin
                        s.run_trough  = angles[n];
                        s.trough_time = tick;
                    end
                    if (s.arm_peak)
                    begin
                        s.held_peak  = s.run_peak;
                        s.peak_begin = s.peak_end;
                        s.peak_end   = s.peak_time;
                        if (s.peak_skip != 0)
                            s.peak_skip--;
                        if (s.peak_skip == 0)
                            s.period = s.peak_end - s.peak_begin;
                    end
                    s.run_peak   = 0;
                    s.arm_peak   = 1'b0;
                    s.arm_trough = 1'b1;
                end
                // Positive half: follow the peak and latch the finished trough once.
                if (angles[n] > db)
                begin
                    if (angles[n] > s.run_peak)
                    begin
                        s.run_peak  = angles[n];
                        s.peak_time = tick;
                    end
                    if (s.arm_trough)
                    begin
                        s.held_trough  = s.run_trough;
                        s.trough_begin = s.trough_end;
                        s.trough_end   = s.trough_time;
                        if (s.trough_skip != 0)
                            s.trough_skip--;
                        if (s.trough_skip == 0)
                            s.period = s.trough_end - s.trough_begin;
                    end
                    s.run_trough = 0;
                    s.arm_trough = 1'b0;
                    s.arm_peak   = 1'b1;
                end
                axis_state[n] = s;

                // Results stay zero until a skip counter runs out, and again after a timeout.
                if (s.peak_skip == 0 || s.trough_skip == 0)
                begin
                    age_t = tick - s.trough_begin;
                    age_p = tick - s.peak_begin;
                    if (!(age_t > timeout_ticks && age_p > timeout_ticks))
                    begin
                        sum = s.held_peak + s.held_trough;
                        dif = s.held_peak - s.held_trough;
                        want[n].offset    = 16'(sum >>> 1);
                        want[n].amplitude = 15'(dif >>> 1);
                        want[n].period    = s.period;
                        want[n].valid     = 1'b1;
                    end
                end
            end
            tick++;
            expected_results.push_back(want);
        endfunction

        function void compare_field(string name, logic signed [63:0] want,
                                    logic signed [63:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        // Checks one accepted result item against the oldest prediction.
        function void check_result(oapt_pkg::out_item_t item);
            lane_set_t got;
            lane_set_t want;
            string     ax;

            if (expected_results.size() == 0)
            begin
                $error("result item arrived with no sample item outstanding");
                failures++;
                return;
            end
            want = expected_results.pop_front();
            got  = lane_set_t'(item);
            for (int n = 0; n < oapt_pkg::NUM_OUT_AXES; n++)
            begin
                ax = (n == 0) ? "x" : (n == 1) ? "y" : "z";
                compare_field({"offset_", ax}, want[n].offset, got[n].offset);
                compare_field({"amplitude_", ax}, want[n].amplitude, got[n].amplitude);
                compare_field({"period_", ax}, want[n].period, got[n].period);
                compare_field({"valid_", ax}, want[n].valid, got[n].valid);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void finish_check();
            if (expected_results.size() != 0)
            begin
                $error("%0d result items never arrived", expected_results.size());
                failures++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    oapt_pkg::in_item_t              in_data;
    logic                            out_valid;
    logic                            out_stall;
    oapt_pkg::out_item_t             out_data;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [oapt_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [oapt_pkg::CFG_DATA_W-1:0] cfg_data;

    oscillation_scoreboard sb;
    int idle_pct;
    bit hold_req;
    int cur_db;
    int wave_sign[oapt_pkg::NUM_OUT_AXES];
    int wave_left[oapt_pkg::NUM_OUT_AXES];
    int wave_amp[oapt_pkg::NUM_OUT_AXES];

    // Band edges, field extremes, repeated crossings and a sample lying inside the band.
    int directed[NUM_DIRECTED][3] = '{
        '{0, 0, 0},              '{64, -64, 63},        '{-64, 64, -63},
        '{65, -65, 0},           '{-65, 65, 0},         '{32767, -32768, 23040},
        '{-32768, 32767, -23040}, '{200, -200, 1000},   '{-300, 300, -1000},
        '{400, -400, 2000},      '{-500, 500, -2000},   '{600, -600, 3000},
        '{-700, 700, -3000},     '{64, 0, -64},         '{800, -800, 23040},
        '{-900, 900, -23040},    '{1000, -1000, 32767}, '{-32768, 32767, -32768},
        '{0, 0, 0},              '{120, -120, 65},      '{-120, 120, -65},
        '{23040, -23040, 5},     '{-23040, 23040, -5}
    };

    oscillation_amplitude_period_tracker u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watches every handshake and feeds the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.note_cfg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                sb.note_sample(in_data);
            if (out_valid && !out_stall)
                sb.check_result(out_data);
        end
    end

    // Result side: random stalls, plus one long hold-off when asked for.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                for (int k = 0; k < HOLD_OFF_CYCLES; k++)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // The run ends here if the block stops moving.
    initial
    begin
        #800000;
        $display("Test completed with failures");
        $finish;
    end

    // Next angle of one axis: mostly halves of random length and height, some noise.
    function automatic int next_angle(int n);
        int hi;
        int lo;
        int mag;

        if (cur_db >= 32767)
            return ($urandom_range(3) == 0) ? -32768 : int'($signed(16'($urandom)));
        lo = cur_db + 1;
        if (wave_left[n] == 0)
        begin
            wave_sign[n] = -wave_sign[n];
            wave_left[n] = $urandom_range(14, 1);
            hi = ($urandom_range(15) == 0) ? 32767 : 23040;
            wave_amp[n] = (lo > hi) ? 32767 : $urandom_range(hi, lo);
        end
        wave_left[n]--;
        case ($urandom_range(19))
            0:       return int'($signed(16'($urandom)));
            1, 2:    return int'($urandom_range(2 * cur_db, 0)) - cur_db;
            default:
            begin
                mag = $urandom_range(wave_amp[n], lo);
                if (wave_sign[n] < 0 && mag == 32767 && $urandom_range(1) == 1)
                    mag = 32768;
                return wave_sign[n] * mag;
            end
        endcase
    endfunction

    // Offers one sample item, after a random gap, and waits until it is taken.
    task automatic send_sample(int ax, int ay, int az);
        oapt_pkg::in_item_t item;

        item.angle_x = 16'(ax);
        item.angle_y = 16'(ay);
        item.angle_z = 16'(az);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Raises a register write and waits for it to be taken; the caller lowers valid.
    task automatic write_cfg(logic [oapt_pkg::CFG_IDX_W-1:0] idx,
                             logic [oapt_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == oapt_pkg::CFG_IDX_DEAD_BAND)
            cur_db = int'(data[oapt_pkg::DEAD_BAND_W-1:0]);
    endtask

    // Stops offering items and waits until every expected result item is in.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int count;

        sb = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        idle_pct  = 0;
        hold_req  = 1'b0;
        cur_db    = oapt_pkg::DEAD_BAND_RESET;
        for (int n = 0; n < oapt_pkg::NUM_OUT_AXES; n++)
        begin
            wave_sign[n] = 1;
            wave_left[n] = 0;
            wave_amp[n]  = 0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items with the reset settings.
        idle_pct = 14;
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_sample(directed[i][0], directed[i][1], directed[i][2]);
        settle();

        // Random phases, each under its own settings.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct = 14;
                    count    = 180;
                end
                1:
                begin
                    write_cfg(oapt_pkg::CFG_IDX_DEAD_BAND, 32'd0);
                    write_cfg(oapt_pkg::CFG_IDX_TIMEOUT, 32'hFFFF_FFFF);
                    write_cfg(oapt_pkg::CFG_IDX_SKIP, 32'd0);
                    write_cfg(CFG_IDX_UNUSED, $urandom);
                    idle_pct = 0;
                    count    = 180;
                end
                2:
                begin
                    write_cfg(oapt_pkg::CFG_IDX_DEAD_BAND, 32'h7FFF);
                    write_cfg(oapt_pkg::CFG_IDX_TIMEOUT, 32'd0);
                    write_cfg(oapt_pkg::CFG_IDX_SKIP, 32'd15);
                    idle_pct = 14;
                    count    = 50;
                end
                3:
                begin
                    write_cfg(oapt_pkg::CFG_IDX_DEAD_BAND, {17'($urandom), 15'd23040});
                    write_cfg(oapt_pkg::CFG_IDX_TIMEOUT, $urandom_range(60, 10));
                    count = 180;
                end
                default:
                begin
                    write_cfg(oapt_pkg::CFG_IDX_DEAD_BAND, $urandom_range(400, 1));
                    write_cfg(oapt_pkg::CFG_IDX_TIMEOUT, $urandom);
                    write_cfg(oapt_pkg::CFG_IDX_SKIP, $urandom);
                    count = 200;
                end
            endcase
            cfg_valid <= 1'b0;

            // In the first phase the result side holds off while items keep coming.
            fork
                begin
                    for (int k = 0; k < count; k++)
                        send_sample(next_angle(0), next_angle(1), next_angle(2));
                end
                begin
                    if (phase == 0)
                    begin
                        repeat (40) @(posedge clk);
                        hold_req = 1'b1;
                    end
                end
            join
            settle();
        end

        sb.finish_check();
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
